FILE: sv/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by lkv_ctrl, lkv_datapath and lru_key_value_cache_unit; no dependencies.
`default_nettype none

package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

  // Register map
  localparam logic [1:0] ADDR_CAPACITY = 2'd0;

  // Operation codes carried on the input tuser
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic load_in;  // capture the accepted request
    logic lookup;   // compare keys, find LRU and free slots
    logic update;   // write the store and load the result register
  } dp_cmd_t;

endpackage

`default_nettype wire

FILE: sv/lkv_ctrl.sv
// Sequencer for the LRU key-value cache: request handshake, lookup/update steps.
// Depends on lkv_pkg; drives lkv_datapath through a dp_cmd_t command bundle.
`default_nettype none

module lkv_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output lkv_pkg::dp_cmd_t     cmd
);
  import lkv_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   out_free;

  assign s_tready = (state == ST_IDLE) || (state == ST_UPDATE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        // hold in lookup until the result register can take the answer
        if (out_free) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = accept ? ST_LOOKUP : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load_in = accept;
    cmd.lookup  = (state == ST_LOOKUP);
    cmd.update  = (state == ST_UPDATE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_UPDATE) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/lkv_datapath.sv
// Entry store, parallel key compare, recency ranks and result register.
// Depends on lkv_pkg; steered by lkv_ctrl through dp_cmd_t.
`default_nettype none

module lkv_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lkv_pkg::dp_cmd_t          cmd,
  input  wire logic [lkv_pkg::CAP_W-1:0] eff_cap,
  input  wire logic [63:0]               s_tdata,  // key, value
  input  wire logic                      s_tuser,  // command
  output logic [63:0]                    m_tdata,  // read_value, evicted_key
  output logic [1:0]                     m_tuser   // hit, evicted
);
  import lkv_pkg::*;

  // Request registers
  logic             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  // Store
  logic [KEY_W-1:0] entry_key   [ENTRIES];
  logic [VAL_W-1:0] entry_value [ENTRIES];
  logic [IDX_W-1:0] rank        [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic [CNT_W-1:0] held_count;

  // Lookup results
  logic             hit_q;
  logic             full_q;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] lru_idx;
  logic [IDX_W-1:0] free_idx;

  // Result register
  logic             out_hit;
  logic             out_ev;
  logic [VAL_W-1:0] out_rd;
  logic [KEY_W-1:0] out_evk;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] is_lru;
  logic [IDX_W-1:0]   match_enc;
  logic [IDX_W-1:0]   lru_enc;
  logic [IDX_W-1:0]   free_enc;
  logic [IDX_W-1:0]   lru_rank;
  logic [IDX_W-1:0]   slot;
  logic [IDX_W-1:0]   hit_rank;

  // Held entries carry distinct ranks 0..held_count-1, so the LRU entry is the
  // one whose rank equals held_count-1.
  assign lru_rank = IDX_W'(held_count - CNT_W'(1));

  always_comb begin
    match_enc = '0;
    lru_enc   = '0;
    free_enc  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = entry_valid[i] && (entry_key[i] == key_q);
      is_lru[i] = entry_valid[i] && (rank[i] == lru_rank);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i])        match_enc = IDX_W'(i);
      if (is_lru[i])       lru_enc   = IDX_W'(i);
      if (!entry_valid[i]) free_enc  = IDX_W'(i);
    end
  end

  assign slot     = full_q ? lru_idx : free_idx;
  assign hit_rank = rank[hit_idx];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_q <= s_tuser;
      key_q <= s_tdata[KEY_W-1:0];
      val_q <= s_tdata[KEY_W+VAL_W-1:KEY_W];
    end
    if (cmd.lookup) begin
      hit_q    <= |match;
      hit_idx  <= match_enc;
      lru_idx  <= lru_enc;
      free_idx <= free_enc;
      full_q   <= (held_count >= CNT_W'(eff_cap));
    end
    if (cmd.update) begin
      out_hit <= hit_q;
      out_ev  <= 1'b0;
      out_rd  <= '0;
      out_evk <= '0;
      if (hit_q) begin
        if (cmd_q == CMD_GET) begin
          out_rd <= entry_value[hit_idx];
        end else begin
          entry_value[hit_idx] <= val_q;
        end
        // promote: younger entries age by one
        for (int i = 0; i < ENTRIES; i++) begin
          if (entry_valid[i] && rank[i] < hit_rank) rank[i] <= rank[i] + IDX_W'(1);
        end
        rank[hit_idx] <= '0;
      end else if (cmd_q == CMD_PUT) begin
        if (full_q) begin
          out_ev  <= 1'b1;
          out_evk <= entry_key[lru_idx];
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (entry_valid[i]) rank[i] <= rank[i] + IDX_W'(1);
        end
        entry_key[slot]   <= key_q;
        entry_value[slot] <= val_q;
        rank[slot]        <= '0;
      end
    end
  end

  // Valid bits and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      held_count  <= '0;
    end else if (cmd.update && !hit_q && (cmd_q == CMD_PUT)) begin
      entry_valid[slot] <= 1'b1;
      if (!full_q) held_count <= held_count + CNT_W'(1);
    end
  end

  assign m_tdata = {out_evk, out_rd};
  assign m_tuser = {out_ev, out_hit};

endmodule

`default_nettype wire

FILE: sv/lru_key_value_cache_unit.sv
// Top level of the LRU key-value cache: stream ports, APB capacity register.
// Depends on lkv_pkg, lkv_ctrl and lkv_datapath.
//
// Fully associative 16-entry key-value cache with least-recently-used
// replacement. Each request is a get or a put (s_tuser), with key and value on
// s_tdata; each request gives exactly one result on the m_ side. A request goes
// through two steps: the parallel compare of the key against all sixteen
// entries (with the LRU and free-slot search), then the store and recency
// update, which also loads the result register. A new request can be accepted
// during the update step of the one before; a stalled result holds the next
// request in its compare step. Capacity (address 0) treats 0 as 1 and values
// above 16 as 16; write it only while the cache is idle. Reset empties the
// cache at once, no clearing pass.
`default_nettype none

module lru_key_value_cache_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [31:0] key, [63:32] value
  input  wire logic        s_tuser,   // [0] command
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [31:0] read_value, [63:32] evicted_key
  output logic [1:0]       m_tuser,   // [0] hit, [1] evicted
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lkv_pkg::*;

  dp_cmd_t          cmd;
  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] eff_cap;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_CAPACITY) ? {{(32 - CAP_W){1'b0}}, capacity} : '0;

  always_comb begin
    eff_cap = capacity;
    if (capacity == '0) eff_cap = CAP_W'(1);
    if (capacity > CAP_W'(ENTRIES)) eff_cap = CAP_W'(ENTRIES);
  end

  lkv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  lkv_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .eff_cap (eff_cap),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

`default_nettype wire

FILE: tb/tb_lru_key_value_cache_unit.sv
// Self-checking testbench for lru_key_value_cache_unit: get/put requests on the
// stream side, capacity writes over APB, results checked against an LRU predictor.
// Depends on lkv_pkg and the lru_key_value_cache_unit RTL.
`timescale 1ns / 1ps

module tb_lru_key_value_cache_unit;
  import lkv_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 24;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lookup_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // [31:0] key, [63:32] value
  logic        s_tuser = 1'b0; // [0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // [31:0] read_value, [63:32] evicted_key
  logic [1:0]  m_tuser;        // [0] hit, [1] evicted
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lru_key_value_cache_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted cache contents
  logic [31:0]      slot_key   [ENTRIES];
  logic [31:0]      slot_value [ENTRIES];
  bit               slot_valid [ENTRIES];
  logic [3:0]       slot_rank  [ENTRIES];
  int               held_entries;
  logic [CAP_W-1:0] capacity_reg;

  lookup_result_t pending_lookups[$];
  int             mismatch_count;
  bit             back_to_back;
  logic [31:0]    key_pool[POOL_SIZE];
  int             cycle_count;

  function automatic int effective_capacity(logic [CAP_W-1:0] c);
    if (c == 0) return 1;
    if (c > ENTRIES) return ENTRIES;
    return int'(c);
  endfunction

  function automatic lookup_result_t cache_access(logic cmd, logic [31:0] key,
                                                  logic [31:0] val);
    lookup_result_t r;
    int found;
    int slot;
    logic [3:0] prior;
    logic [3:0] oldest;
    r = '0;
    found = -1;
    slot = -1;
    oldest = '0;
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
    if (found >= 0) begin
      r.hit = 1'b1;
      if (cmd == CMD_GET) r.read_value = slot_value[found];
      else slot_value[found] = val;
      prior = slot_rank[found];
      for (int i = 0; i < ENTRIES; i++)
        if (slot_valid[i] && slot_rank[i] < prior) slot_rank[i]++;
      slot_rank[found] = '0;
    end else if (cmd == CMD_PUT) begin
      if (held_entries >= effective_capacity(capacity_reg)) begin
        // victim is the held entry with the largest rank
        for (int i = 0; i < ENTRIES; i++)
          if (slot_valid[i] && (slot < 0 || slot_rank[i] > oldest)) begin
            slot = i;
            oldest = slot_rank[i];
          end
        if (slot >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = slot_key[slot];
          slot_valid[slot] = 1'b0;
          held_entries--;
        end
      end
      if (slot < 0)
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!slot_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot_valid[i]) slot_rank[i]++;
        slot_key[slot] = key;
        slot_value[slot] = val;
        slot_valid[slot] = 1'b1;
        slot_rank[slot] = '0;
        held_entries++;
      end
    end
    return r;
  endfunction

  // Present one request, hold it until accepted, then predict its result.
  task automatic issue_request(input logic cmd, input logic [31:0] key,
                               input logic [31:0] val);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, key};
    s_tuser  <= cmd;
    do @(posedge clk); while (s_tready !== 1'b1);
    pending_lookups.push_back(cache_access(cmd, key, val));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CAPACITY;
    pwdata  <= {27'($urandom), cap};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    capacity_reg = cap;
  endtask

  // Empty cache at reset capacity: misses, hits, overwrite, extreme keys.
  task automatic test_get_put_basics();
    issue_request(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    issue_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    issue_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    issue_request(CMD_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    issue_request(CMD_GET, 32'h7FFF_FFFF, 32'h1234_5678);
    issue_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    issue_request(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    issue_request(CMD_PUT, 32'h0000_0000, 32'hA5A5_5A5A);
    issue_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    issue_request(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    drain_results();
  endtask

  // Capacity 0 acts as 1 while four entries are held: each put miss evicts one.
  task automatic test_capacity_below_held();
    write_capacity(5'd0);
    issue_request(CMD_PUT, 32'h0000_0001, 32'h1111_1111);
    issue_request(CMD_PUT, 32'h0000_0002, 32'h2222_2222);
    issue_request(CMD_GET, 32'h0000_0002, 32'h0000_0000);
    issue_request(CMD_PUT, 32'h0000_0002, 32'h3333_3333);
    issue_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    issue_request(CMD_GET, 32'h0000_0001, 32'h0000_0000);
    drain_results();
  endtask

  // Capacity above the entry count saturates: new keys fill free slots.
  task automatic test_capacity_saturation();
    write_capacity(5'd31);
    issue_request(CMD_PUT, 32'hDEAD_BEEF, 32'h0000_0001);
    issue_request(CMD_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    issue_request(CMD_GET, 32'h0000_0002, 32'h0000_0000);
    drain_results();
  endtask

  // Random gets and puts over a key pool sized a little above the capacity.
  task automatic test_random_traffic();
    logic [CAP_W-1:0] phase_caps[10];
    int span;
    logic cmd;
    logic [31:0] key;
    logic [31:0] val;
    phase_caps = '{5'd17, 5'd1, 5'd3, 5'd31, 5'd16, 5'd0, 5'd8, 5'd2,
                   5'($urandom), 5'($urandom)};
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int phase = 0; phase < 10; phase++) begin
      write_capacity(phase_caps[phase]);
      back_to_back = (phase % 4 == 3);
      span = effective_capacity(phase_caps[phase]) + 6;
      if (span > POOL_SIZE) span = POOL_SIZE;
      for (int n = 0; n < 70; n++) begin
        cmd = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 15) == 0) key = $urandom;
        else key = key_pool[$urandom_range(0, span - 1)];
        case ($urandom_range(0, 7))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          default: val = $urandom;
        endcase
        issue_request(cmd, key, val);
      end
      drain_results();
    end
    back_to_back = 1'b0;
  endtask

  // Result side: random stall per result outside back-to-back phases, compare with the oldest prediction.
  initial begin
    lookup_result_t want;
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = back_to_back ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      if (pending_lookups.size() == 0) begin
        $error("result with no request pending");
        mismatch_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (m_tuser[0] !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, m_tuser[0]);
          mismatch_count++;
        end
        if (m_tdata[31:0] !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, m_tdata[31:0]);
          mismatch_count++;
        end
        if (m_tuser[1] !== want.evicted) begin
          $error("evicted: expected %0d, got %0d", want.evicted, m_tuser[1]);
          mismatch_count++;
        end
        if (m_tdata[63:32] !== want.evicted_key) begin
          $error("evicted_key: expected %h, got %h", want.evicted_key, m_tdata[63:32]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_lru_key_value_cache_unit: done, errors");
      $finish;
    end
  end

  initial begin
    cycle_count    = 0;
    mismatch_count = 0;
    back_to_back   = 1'b0;
    held_entries   = 0;
    capacity_reg   = CAP_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_rank[i]  = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_get_put_basics();
    test_capacity_below_held();
    test_capacity_saturation();
    test_random_traffic();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_lru_key_value_cache_unit: done, clean");
    else
      $display("tb_lru_key_value_cache_unit: done, errors");
    $finish;
  end

endmodule
